>>> hdl/stip_pkg.sv
// stip_pkg: shared types, constants and helpers for the string-to-integer parser
// no dependencies; imported by stip_cfg, stip_step, string_to_integer_parser, stip_checker and the testbench
package stip_pkg;

  // default widths of the value accumulator and the character counter
  localparam int unsigned VALUE_WIDTH_DEF = 64;
  localparam int unsigned COUNT_WIDTH_DEF = 16;

  // payload widths of the result fields
  localparam int unsigned OUT_VALUE_W = 64;
  localparam int unsigned OUT_COUNT_W = 16;

  // parse phase codes
  localparam logic [1:0] PH_SPACE  = 2'd0;
  localparam logic [1:0] PH_PREFIX = 2'd1;
  localparam logic [1:0] PH_ZERO   = 2'd2;
  localparam logic [1:0] PH_DIGITS = 2'd3;

  // register indexes on the config port
  localparam logic REG_NUMBER_BASE = 1'b0;
  localparam logic REG_SIGNED_MODE = 1'b1;

  // register reset values
  localparam logic [4:0] NUMBER_BASE_RST = 5'd10;
  localparam logic       SIGNED_MODE_RST = 1'b1;

  // radix values used by prefix resolution
  localparam logic [4:0] BASE_AUTO = 5'd0;
  localparam logic [4:0] BASE_OCT  = 5'd8;
  localparam logic [4:0] BASE_DEC  = 5'd10;
  localparam logic [4:0] BASE_HEX  = 5'd16;

  // character codes
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_LA    = 8'h61;
  localparam logic [7:0] CHAR_LF    = 8'h66;
  localparam logic [7:0] CHAR_UA    = 8'h41;
  localparam logic [7:0] CHAR_UF    = 8'h46;
  localparam logic [7:0] CHAR_LX    = 8'h78;
  localparam logic [7:0] CHAR_UX    = 8'h58;

  // digit code for characters that are no digit; never below any 5-bit radix
  localparam logic [4:0] DIGIT_NONE = 5'h1F;

  typedef struct packed {
    logic [7:0] char_code;
    logic       start_of_string;
  } in_t;

  typedef struct packed {
    logic [OUT_VALUE_W-1:0] parsed_value;
    logic [OUT_COUNT_W-1:0] consumed_count;
  } out_t;

  typedef struct packed {
    logic [4:0] number_base;
    logic       signed_mode;
  } cfg_t;

  // parse control state
  typedef struct packed {
    logic [1:0] phase;
    logic       neg;
    logic [4:0] base;
    logic       fin;
  } ctl_t;

  // digit value of a character, DIGIT_NONE when it is no hex digit
  function automatic logic [4:0] digit_of(input logic [7:0] c);
    logic [7:0] d;
    d = 8'd0;
    if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      d = c - CHAR_ZERO;
      return d[4:0];
    end else if (c >= CHAR_LA && c <= CHAR_LF) begin
      d = c - CHAR_LA + 8'd10;
      return d[4:0];
    end else if (c >= CHAR_UA && c <= CHAR_UF) begin
      d = c - CHAR_UA + 8'd10;
      return d[4:0];
    end
    return DIGIT_NONE;
  endfunction

endpackage

>>> hdl/stip_cfg.sv
// stip_cfg: APB-style register file holding the radix and the signed mode
// depends on stip_pkg
module stip_cfg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output stip_pkg::cfg_t cfg_o
);
  import stip_pkg::*;

  logic [4:0] base_q, base_d;
  logic       sgn_q, sgn_d;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // register write decode
  always_comb begin
    base_d = base_q;
    sgn_d  = sgn_q;
    if (wr_en) begin
      unique case (paddr[2])
        REG_NUMBER_BASE: base_d = pwdata[4:0];
        REG_SIGNED_MODE: sgn_d  = pwdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= NUMBER_BASE_RST;
      sgn_q  <= SIGNED_MODE_RST;
    end else begin
      base_q <= base_d;
      sgn_q  <= sgn_d;
    end
  end

  // register read decode
  always_comb begin
    unique case (paddr[2])
      REG_NUMBER_BASE: prdata = {27'd0, base_q};
      REG_SIGNED_MODE: prdata = {31'd0, sgn_q};
      default:         prdata = 32'd0;
    endcase
  end

  assign cfg_o.number_base = base_q;
  assign cfg_o.signed_mode = sgn_q;

endmodule

>>> hdl/stip_step.sv
// stip_step: next-state logic for one character: whitespace, sign, prefix and digits
// depends on stip_pkg; purely combinational, registered by the top level
module stip_step #(
  parameter int unsigned VALUE_WIDTH = stip_pkg::VALUE_WIDTH_DEF,
  parameter int unsigned COUNT_WIDTH = stip_pkg::COUNT_WIDTH_DEF
) (
  input  stip_pkg::in_t          in_i,
  input  stip_pkg::cfg_t         cfg_i,
  input  stip_pkg::ctl_t         ctl_i,
  input  logic [VALUE_WIDTH-1:0] acc_i,
  input  logic [COUNT_WIDTH-1:0] cnt_i,
  output stip_pkg::ctl_t         ctl_o,
  output logic [VALUE_WIDTH-1:0] acc_o,
  output logic [COUNT_WIDTH-1:0] cnt_o,
  output logic                   res_valid_o,
  output logic [VALUE_WIDTH-1:0] res_value_o,
  output logic [COUNT_WIDTH-1:0] res_count_o
);
  import stip_pkg::*;

  ctl_t                   cur_ctl;
  logic [VALUE_WIDTH-1:0] cur_acc;
  logic [COUNT_WIDTH-1:0] cur_cnt;
  logic [COUNT_WIDTH-1:0] cnt_inc1, cnt_inc2;
  logic [COUNT_WIDTH-1:0] dig_cnt, dig_cnt_inc;
  logic [4:0]             dig_base, digit, pre_base;
  logic                   take, prefix, is_ws, is_sign;
  logic [VALUE_WIDTH-1:0] mac;

  // a new string clears the parse state first
  always_comb begin
    cur_ctl = ctl_i;
    cur_acc = acc_i;
    cur_cnt = cnt_i;
    if (in_i.start_of_string) begin
      cur_ctl.phase = PH_SPACE;
      cur_ctl.neg   = 1'b0;
      cur_ctl.base  = cfg_i.number_base;
      cur_ctl.fin   = 1'b0;
      cur_acc       = '0;
      cur_cnt       = '0;
    end
  end

  // character classes
  assign digit   = digit_of(in_i.char_code);
  assign is_ws   = (in_i.char_code == CHAR_SPACE) ||
                   (in_i.char_code >= CHAR_TAB && in_i.char_code <= CHAR_CR);
  assign is_sign = (in_i.char_code == CHAR_PLUS) ||
                   (in_i.char_code == CHAR_MINUS && cfg_i.signed_mode);

  // saturating counter increments
  assign cnt_inc1    = (&cur_cnt) ? cur_cnt : cur_cnt + COUNT_WIDTH'(1);
  assign cnt_inc2    = (&cnt_inc1) ? cnt_inc1 : cnt_inc1 + COUNT_WIDTH'(1);
  assign dig_cnt_inc = (&dig_cnt) ? dig_cnt : dig_cnt + COUNT_WIDTH'(1);

  // radix once the prefix position is passed without a leading zero
  assign pre_base = (cur_ctl.base == BASE_AUTO) ? BASE_DEC : cur_ctl.base;

  // multiply-add of the accumulator by the selected radix
  assign mac = VALUE_WIDTH'(cur_acc * VALUE_WIDTH'(dig_base)) + VALUE_WIDTH'(digit);

  // phase sequencing
  always_comb begin
    ctl_o       = cur_ctl;
    acc_o       = cur_acc;
    cnt_o       = cur_cnt;
    res_valid_o = 1'b0;
    res_value_o = cur_acc;
    res_count_o = cur_cnt;
    take        = 1'b0;
    prefix      = 1'b0;
    dig_base    = cur_ctl.base;
    dig_cnt     = cur_cnt;
    if (!cur_ctl.fin) begin
      unique case (cur_ctl.phase)
        PH_SPACE: begin
          if (is_ws) begin
            cnt_o = cnt_inc1;
          end else if (is_sign) begin
            ctl_o.neg   = (in_i.char_code == CHAR_MINUS);
            ctl_o.phase = PH_PREFIX;
            cnt_o       = cnt_inc1;
          end else begin
            prefix = 1'b1;
          end
        end
        PH_PREFIX: begin
          prefix = 1'b1;
        end
        PH_ZERO: begin
          ctl_o.phase = PH_DIGITS;
          if (in_i.char_code == CHAR_LX || in_i.char_code == CHAR_UX) begin
            ctl_o.base = BASE_HEX;
            cnt_o      = cnt_inc2;
          end else begin
            if (cur_ctl.base == BASE_AUTO) begin
              ctl_o.base = BASE_OCT;
              dig_base   = BASE_OCT;
            end
            take    = 1'b1;
            dig_cnt = cnt_inc1;
          end
        end
        default: begin
          take = 1'b1;
        end
      endcase

      // leading zero may open a prefix, anything else resolves the radix
      if (prefix) begin
        if ((cur_ctl.base == BASE_AUTO || cur_ctl.base == BASE_HEX) &&
            in_i.char_code == CHAR_ZERO) begin
          ctl_o.phase = PH_ZERO;
        end else begin
          ctl_o.phase = PH_DIGITS;
          ctl_o.base  = pre_base;
          dig_base    = pre_base;
          take        = 1'b1;
        end
      end

      // digit accumulate or stop
      if (take) begin
        if (digit < dig_base) begin
          acc_o = mac;
          cnt_o = dig_cnt_inc;
        end else begin
          cnt_o       = dig_cnt;
          ctl_o.fin   = 1'b1;
          res_valid_o = 1'b1;
          res_value_o = cur_ctl.neg ? VALUE_WIDTH'(0) - cur_acc : cur_acc;
          res_count_o = dig_cnt;
        end
      end
    end
  end

endmodule

>>> hdl/string_to_integer_parser.sv
// Streaming string-to-integer parser, one character per transaction.
// Result path: a stop character goes through the input register, then the result register.
// Throughput: one character per cycle unless a blocked result stalls the input; the parse
// state loop through the VALUE_WIDTH by 5 bit multiply-add sets the cycle time.
// Reset: asynchronous, active low; parser idles until a start_of_string, radix 10,
// signed mode on. Depends on stip_pkg, stip_cfg and stip_step.
module string_to_integer_parser #(
  parameter int unsigned VALUE_WIDTH = stip_pkg::VALUE_WIDTH_DEF,
  parameter int unsigned COUNT_WIDTH = stip_pkg::COUNT_WIDTH_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  stip_pkg::in_t  in_data_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  output stip_pkg::out_t out_data_o,
  input  logic           out_stall_i,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [2:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);
  import stip_pkg::*;

  cfg_t                   cfg;
  logic                   in_valid_q, in_valid_d;
  in_t                    in_q;
  ctl_t                   ctl_q, ctl_d;
  logic [VALUE_WIDTH-1:0] acc_q, acc_d;
  logic [COUNT_WIDTH-1:0] cnt_q, cnt_d;
  logic                   res_valid;
  logic [VALUE_WIDTH-1:0] res_value;
  logic [COUNT_WIDTH-1:0] res_count;
  logic                   out_valid_q, out_valid_d;
  out_t                   out_q;
  logic                   in_accept, step_fire, out_take;
  logic [VALUE_WIDTH+OUT_VALUE_W-1:0] val_ext;
  logic [COUNT_WIDTH+OUT_COUNT_W-1:0] cnt_ext;

  // config registers
  stip_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // handshakes: the buffered character moves on unless the result register is blocked
  assign out_take   = out_valid_q && !out_stall_i;
  assign step_fire  = in_valid_q && !(out_valid_q && out_stall_i);
  assign in_stall_o = in_valid_q && !step_fire;
  assign in_accept  = in_valid_i && !in_stall_o;

  // input register
  assign in_valid_d = in_accept || (in_valid_q && !step_fire);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_q <= in_data_i;
    end
  end

  // per-character next state
  stip_step #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_step (
    .in_i        (in_q),
    .cfg_i       (cfg),
    .ctl_i       (ctl_q),
    .acc_i       (acc_q),
    .cnt_i       (cnt_q),
    .ctl_o       (ctl_d),
    .acc_o       (acc_d),
    .cnt_o       (cnt_d),
    .res_valid_o (res_valid),
    .res_value_o (res_value),
    .res_count_o (res_count)
  );

  // parse state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '{phase: PH_SPACE, neg: 1'b0, base: BASE_AUTO, fin: 1'b1};
      acc_q <= '0;
      cnt_q <= '0;
    end else if (step_fire) begin
      ctl_q <= ctl_d;
      acc_q <= acc_d;
      cnt_q <= cnt_d;
    end
  end

  // result fields at payload width
  assign val_ext = {{OUT_VALUE_W{1'b0}}, res_value};
  assign cnt_ext = {{OUT_COUNT_W{1'b0}}, res_count};

  // result register
  assign out_valid_d = (step_fire && res_valid) || (out_valid_q && !out_take);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_fire && res_valid) begin
      out_q.parsed_value   <= val_ext[OUT_VALUE_W-1:0];
      out_q.consumed_count <= cnt_ext[OUT_COUNT_W-1:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // a finished parse gives no result until a new string starts
  a_idle_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_fire && ctl_q.fin && !in_q.start_of_string) |-> !res_valid)
    else $error("result produced while parser idle");

  // digit phase always runs with a resolved radix
  a_digits_base: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_q.phase == PH_DIGITS) |-> (ctl_q.base != BASE_AUTO))
    else $error("digit phase with unresolved radix");

  // the zero lookahead phase only occurs for auto or hex radix
  a_zero_base: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_q.phase == PH_ZERO) |-> (ctl_q.base == BASE_AUTO || ctl_q.base == BASE_HEX))
    else $error("zero lookahead with wrong radix");

  // a new result is never written over one that is still blocked
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !(step_fire && res_valid))
    else $error("result register overwritten while stalled");

endmodule

>>> dv/stip_checker.sv
`timescale 1ns / 100ps
// stip_checker: predicts parsed numbers from the character and register traffic
// of string_to_integer_parser and compares every result transaction in order
// depends on stip_pkg for the payload types, phase codes and character codes
module stip_checker (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_stall_i,
  input  stip_pkg::in_t  in_data_i,
  input  logic           out_valid_i,
  input  logic           out_stall_i,
  input  stip_pkg::out_t out_data_i,
  input  logic           psel_i,
  input  logic           penable_i,
  input  logic           pwrite_i,
  input  logic           pready_i,
  input  logic [2:0]     paddr_i,
  input  logic [31:0]    pwdata_i,
  input  logic [31:0]    prdata_i,
  output int             fail_count_o,
  output int             pending_o
);
  import stip_pkg::*;

  localparam logic [2:0] ADDR_NUMBER_BASE = {REG_NUMBER_BASE, 2'b00};
  localparam logic [2:0] ADDR_SIGNED_MODE = {REG_SIGNED_MODE, 2'b00};
  localparam int unsigned REPORT_MAX = 10;

  // register shadows
  logic [4:0]  base_reg  = NUMBER_BASE_RST;
  logic        smode_reg = SIGNED_MODE_RST;

  // parse state of the predicted block
  logic [1:0]  phase     = PH_SPACE;
  logic [63:0] acc       = '0;
  logic        neg       = 1'b0;
  logic [4:0]  radix     = BASE_AUTO;
  logic [15:0] count     = '0;
  logic        done      = 1'b1;

  out_t expected_numbers[$];
  int   mismatches = 0;

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  // value of a hex digit character, all ones for anything else
  function automatic logic [7:0] char_digit(input logic [7:0] c);
    if (c >= CHAR_ZERO && c <= CHAR_NINE) return c - CHAR_ZERO;
    if (c >= CHAR_LA && c <= CHAR_LF) return c - CHAR_LA + 8'd10;
    if (c >= CHAR_UA && c <= CHAR_UF) return c - CHAR_UA + 8'd10;
    return 8'hFF;
  endfunction

  task automatic flag_mismatch(input string what, input logic [63:0] want,
                               input logic [63:0] got);
    if (mismatches < REPORT_MAX) begin
      $display("[%0t] %s: expected %h, got %h", $realtime, what, want, got);
    end
    mismatches++;
  endtask

  task automatic bump_count();
    if (count != 16'hFFFF) count++;
  endtask

  // one character through the parse state; a stop character queues a number
  task automatic parse_char(input logic [7:0] c, input logic sos);
    logic [7:0] d;
    out_t       num;
    if (sos) begin
      phase = PH_SPACE;
      acc   = '0;
      neg   = 1'b0;
      radix = base_reg;
      count = '0;
      done  = 1'b0;
    end
    if (done) return;
    d = char_digit(c);
    // leading whitespace and sign
    if (phase == PH_SPACE) begin
      if (c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR)) begin
        bump_count();
        return;
      end
      if (c == CHAR_PLUS || (c == CHAR_MINUS && smode_reg)) begin
        neg = (c == CHAR_MINUS);
        bump_count();
        phase = PH_PREFIX;
        return;
      end
      phase = PH_PREFIX;
    end
    // radix prefix resolution
    if (phase == PH_PREFIX) begin
      if ((radix == BASE_AUTO || radix == BASE_HEX) && c == CHAR_ZERO) begin
        phase = PH_ZERO;
        return;
      end
      if (radix == BASE_AUTO) radix = BASE_DEC;
      phase = PH_DIGITS;
    end else if (phase == PH_ZERO) begin
      phase = PH_DIGITS;
      if (c == CHAR_LX || c == CHAR_UX) begin
        radix = BASE_HEX;
        bump_count();
        bump_count();
        return;
      end
      if (radix == BASE_AUTO) radix = BASE_OCT;
      bump_count();
    end
    // digit accumulation or stop
    if (d < {3'b000, radix}) begin
      acc = acc * {59'd0, radix} + {56'd0, d};
      bump_count();
    end else begin
      num.parsed_value   = neg ? (64'd0 - acc) : acc;
      num.consumed_count = count;
      expected_numbers.push_back(num);
      done = 1'b1;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_reg  = NUMBER_BASE_RST;
      smode_reg = SIGNED_MODE_RST;
      phase     = PH_SPACE;
      acc       = '0;
      neg       = 1'b0;
      radix     = BASE_AUTO;
      count     = '0;
      done      = 1'b1;
      expected_numbers.delete();
    end else begin
      // result transaction against the oldest prediction
      if (out_valid_i && !out_stall_i) begin
        if (expected_numbers.size() == 0) begin
          flag_mismatch("result with none expected", '0, out_data_i.parsed_value);
        end else begin
          if (out_data_i.parsed_value != expected_numbers[0].parsed_value) begin
            flag_mismatch("parsed_value", expected_numbers[0].parsed_value,
                          out_data_i.parsed_value);
          end
          if (out_data_i.consumed_count != expected_numbers[0].consumed_count) begin
            flag_mismatch("consumed_count", 64'(expected_numbers[0].consumed_count),
                          64'(out_data_i.consumed_count));
          end
          void'(expected_numbers.pop_front());
        end
      end
      // character transaction
      if (in_valid_i && !in_stall_i) begin
        parse_char(in_data_i.char_code, in_data_i.start_of_string);
      end
      // register access
      if (psel_i && penable_i && pready_i) begin
        if (pwrite_i) begin
          if (paddr_i == ADDR_NUMBER_BASE) base_reg = pwdata_i[4:0];
          if (paddr_i == ADDR_SIGNED_MODE) smode_reg = pwdata_i[0];
        end else if (paddr_i == ADDR_NUMBER_BASE) begin
          if (prdata_i[4:0] != base_reg) begin
            flag_mismatch("number_base readback", 64'(base_reg), 64'(prdata_i[4:0]));
          end
        end else if (paddr_i == ADDR_SIGNED_MODE) begin
          if (prdata_i[0] != smode_reg) begin
            flag_mismatch("signed_mode readback", 64'(smode_reg), 64'(prdata_i[0]));
          end
        end
      end
    end
    fail_count_o <= mismatches;
    pending_o    <= expected_numbers.size();
  end

endmodule

>>> dv/tb_string_to_integer_parser.sv
`timescale 1ns / 100ps
// tb_string_to_integer_parser: drives character strings and register settings
// into string_to_integer_parser with random idling on both channels
// depends on stip_pkg and stip_checker, which predicts and compares the results
module tb_string_to_integer_parser;
  import stip_pkg::*;

  localparam logic [2:0]  ADDR_NUMBER_BASE = {REG_NUMBER_BASE, 2'b00};
  localparam logic [2:0]  ADDR_SIGNED_MODE = {REG_SIGNED_MODE, 2'b00};
  localparam logic [7:0]  NUL = 8'h00;
  localparam int          RANDOM_CHARS = 1800;
  localparam int          PHASE_CHARS = 150;
  localparam int          DRAIN_CYCLES = 8;
  localparam int          CYCLE_LIMIT = 1_000_000;
  localparam int          LONG_SPACES = 60;
  localparam int          LONG_DIGITS = 40;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  in_t         in_data_i = '0;
  logic        in_stall_o;
  logic        out_valid_o;
  out_t        out_data_o;
  logic        out_stall_i = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int failures;
  int pending_results;
  int tx_mode = 0;
  int rx_mode = 0;
  int cycle_count = 0;
  int chars_sent = 0;
  int random_chars = 0;
  int setting_count = 0;
  int unsigned stall_left = 0;
  int unsigned stall_draw;

  string_to_integer_parser dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .out_stall_i (out_stall_i),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  stip_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .in_data_i    (in_data_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_i   (out_data_o),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .pready_i     (pready),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .prdata_i     (prdata),
    .fail_count_o (failures),
    .pending_o    (pending_results)
  );

  // clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // idle gap before one transaction: none, a random one every time, or a rare random burst
  function automatic int unsigned draw_gap(input int mode);
    if (mode == 1) return $urandom_range(0, 12);
    if (mode == 2 && $urandom_range(0, 7) == 0) return $urandom_range(1, 12);
    return 0;
  endfunction

  function automatic logic [7:0] pick_space();
    int unsigned r;
    r = $urandom_range(0, 5);
    return (r == 5) ? CHAR_SPACE : CHAR_TAB + 8'(r);
  endfunction

  // result side may stall after an accepted result
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      if (stall_left == 1) out_stall_i <= 1'b0;
    end else if (out_valid_o && !out_stall_i) begin
      stall_draw = draw_gap(rx_mode);
      if (stall_draw != 0) begin
        out_stall_i <= 1'b1;
        stall_left  <= stall_draw;
      end
    end
  end

  // one character transaction
  task automatic push_char(input logic [7:0] c, input logic sos);
    int unsigned gap;
    in_t         item;
    gap = draw_gap(tx_mode);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    item.char_code       = c;
    item.start_of_string = sos;
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    chars_sent++;
  endtask

  task automatic send_text(input string s, input logic sos);
    for (int i = 0; i < s.len(); i++) push_char(s[i], sos && i == 0);
  endtask

  // hold off until every predicted number has come out
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_access(input logic write, input logic [2:0] addr,
                            input logic [31:0] data);
    psel   <= 1'b1;
    pwrite <= write;
    paddr  <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // write both registers and read them back
  task automatic set_config(input logic [4:0] base, input logic smode);
    apb_access(1'b1, ADDR_NUMBER_BASE, {27'd0, base});
    apb_access(1'b1, ADDR_SIGNED_MODE, {31'd0, smode});
    apb_access(1'b0, ADDR_NUMBER_BASE, '0);
    apb_access(1'b0, ADDR_SIGNED_MODE, '0);
    setting_count++;
  endtask

  // one mostly well-formed string, or a burst of noise
  task automatic send_string(input logic [4:0] base);
    logic [7:0]  text[$];
    int unsigned lim;
    int unsigned v;
    int          n;
    lim = (base == BASE_AUTO || base > BASE_HEX) ? 16 : int'(base);
    if ($urandom_range(0, 9) == 0) begin
      n = $urandom_range(1, 4);
      for (int k = 0; k < n; k++) begin
        push_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end
      random_chars += n;
      return;
    end
    // whitespace, sign and prefix
    n = $urandom_range(0, 3);
    for (int k = 0; k < n; k++) text.push_back(pick_space());
    case ($urandom_range(0, 3))
      1: text.push_back(CHAR_PLUS);
      2: text.push_back(CHAR_MINUS);
      default: ;
    endcase
    case ($urandom_range(0, 5))
      1: text.push_back(CHAR_ZERO);
      2: begin
        text.push_back(CHAR_ZERO);
        text.push_back(CHAR_LX);
      end
      3: begin
        text.push_back(CHAR_ZERO);
        text.push_back(CHAR_UX);
      end
      default: ;
    endcase
    // digits, now and then one out of range
    n = $urandom_range(0, 20);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 15) == 0) v = $urandom_range(0, 15);
      else v = $urandom_range(0, lim - 1);
      if (v < 10) text.push_back(CHAR_ZERO + 8'(v));
      else text.push_back(($urandom_range(0, 1) ? CHAR_LA : CHAR_UA) + 8'(v - 10));
    end
    // stop character; none means the next string abandons this one
    case ($urandom_range(0, 3))
      0, 1: text.push_back(NUL);
      2: text.push_back(8'($urandom_range(0, 255)));
      default: ;
    endcase
    foreach (text[k]) push_char(text[k], k == 0 || $urandom_range(0, 63) == 0);
    random_chars += text.size();
    // trailing character, ignored once the parse has stopped
    if ($urandom_range(0, 7) == 0) push_char(8'($urandom_range(0, 255)), 1'b0);
  endtask

  initial begin
    logic [4:0] base;
    logic       smode;
    int         phase_no;
    int         phase_end;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset settings, radix 10 and signed
    send_text("\t-1", 1'b1);
    push_char(NUL, 1'b0);
    send_text("+x", 1'b1);
    send_text("12", 1'b1);
    send_text("7", 1'b1);
    push_char(NUL, 1'b0);
    push_char("Q", 1'b0);
    // prefix detection, unsigned
    wait_idle();
    set_config(BASE_AUTO, 1'b0);
    send_text("0xg", 1'b1);
    send_text("-", 1'b1);
    send_text("0179", 1'b1);
    send_text("0XfF", 1'b1);
    push_char(8'hFF, 1'b0);
    // odd radixes
    wait_idle();
    set_config(5'd31, 1'b1);
    send_text("fFg", 1'b1);
    wait_idle();
    set_config(5'd1, 1'b1);
    send_text("0", 1'b1);
    push_char(NUL, 1'b0);
    // radix change in the middle of a string keeps the latched radix
    wait_idle();
    set_config(BASE_HEX, 1'b1);
    send_text("1", 1'b1);
    wait_idle();
    set_config(BASE_DEC, 1'b1);
    send_text("a", 1'b0);
    push_char(NUL, 1'b0);

    // random strings over a series of settings
    phase_no = 0;
    while (random_chars < RANDOM_CHARS) begin
      wait_idle();
      case (phase_no)
        0: begin base = BASE_AUTO; smode = 1'b0; end
        1: begin base = BASE_HEX;  smode = 1'b1; end
        2: begin base = 5'd1;      smode = 1'b1; end
        3: begin base = 5'd31;     smode = 1'b0; end
        4: begin base = 5'd2;      smode = 1'b1; end
        5: begin base = BASE_OCT;  smode = 1'b0; end
        6: begin base = BASE_AUTO; smode = 1'b1; end
        default: begin
          base  = 5'($urandom_range(0, 31));
          smode = 1'($urandom_range(0, 1));
        end
      endcase
      set_config(base, smode);
      tx_mode   = $urandom_range(0, 2);
      rx_mode   = $urandom_range(0, 2);
      phase_end = random_chars + PHASE_CHARS;
      while (random_chars < phase_end) send_string(base);
      phase_no++;
    end

    // one long string whose value wraps around the accumulator width
    wait_idle();
    set_config(BASE_DEC, 1'b1);
    tx_mode = 0;
    push_char(pick_space(), 1'b1);
    for (int k = 1; k < LONG_SPACES; k++) push_char(pick_space(), 1'b0);
    for (int k = 0; k < LONG_DIGITS; k++) push_char(CHAR_ZERO + 8'($urandom_range(0, 9)), 1'b0);
    push_char(NUL, 1'b0);

    wait_idle();
    $display("%0d characters over %0d radix and sign settings, %0d of them random",
             chars_sent, setting_count, random_chars);
    $display("prefixes, restarts, odd radixes, idle input and value wraparound covered");
    if (failures == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/stip_pkg.sv
hdl/stip_cfg.sv
hdl/stip_step.sv
hdl/string_to_integer_parser.sv
dv/stip_checker.sv
dv/tb_string_to_integer_parser.sv
